[sv/cal_pkg.sv]
// Shared constants, operation codes and unit interface types for the checked accumulator ALU.
package cal_pkg;

  localparam int DW = 32;
  localparam int HW = DW / 2;
  localparam int CW = $clog2(DW);

  localparam logic [3:0] MODE_LOAD = 4'd0;
  localparam logic [3:0] MODE_NEG  = 4'd1;
  localparam logic [3:0] MODE_INC  = 4'd2;
  localparam logic [3:0] MODE_DEC  = 4'd3;
  localparam logic [3:0] MODE_ADD  = 4'd4;
  localparam logic [3:0] MODE_SUB  = 4'd5;
  localparam logic [3:0] MODE_MUL  = 4'd6;
  localparam logic [3:0] MODE_SHL  = 4'd7;
  localparam logic [3:0] MODE_SHR  = 4'd8;

  typedef struct packed {
    logic [3:0]    mode;
    logic [DW-1:0] a;
    logic [DW-1:0] b;
  } cal_req_t;

  typedef struct packed {
    logic          done;
    logic          refused;
    logic [DW-1:0] value;
  } cal_rsp_t;

endpackage

[sv/cal_unit.sv]
// Iterative ALU unit: one shared adder under a small sequencer (shift-add multiply, bit shifts).
module cal_unit import cal_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  cal_req_t req,
  input  logic     ack,
  output cal_rsp_t rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAGA = 3'd1;
  localparam logic [2:0] S_MAGB = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_SHL  = 3'd5;
  localparam logic [2:0] S_SHR  = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]    state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [DW-1:0] hi, hi_next;
  logic [DW-1:0] lo, lo_next;
  logic [DW-1:0] mcand, mcand_next;
  logic          neg, neg_next;
  logic          lost, lost_next;
  logic [DW-1:0] res_value, res_value_next;
  logic          res_ref, res_ref_next;

  logic [DW-1:0] add_x, add_y;
  logic          add_sub;
  logic [DW:0]   add_sum;
  logic [DW-1:0] add_r;
  logic          add_ovf;
  logic          amt_bad;
  logic [CW-1:0] amt;
  logic          big;
  logic [DW-1:0] shl_val;
  logic [DW-1:0] shr_val;

  // Shared adder: x + y, or x - y as x + ~y + 1
  assign add_sum = {1'b0, add_x} + {1'b0, add_y ^ {DW{add_sub}}} + {{DW{1'b0}}, add_sub};
  assign add_r   = add_sum[DW-1:0];
  assign add_ovf = add_sub ? (add_x[DW-1] ^ add_y[DW-1]) & (add_x[DW-1] ^ add_r[DW-1])
                           : (add_x[DW-1] ^ add_r[DW-1]) & (add_y[DW-1] ^ add_r[DW-1]);

  // Shift amount checks and one-bit shift steps
  assign amt_bad = req.b[DW-1] || (req.b[DW-2:CW] != '0);
  assign amt     = req.b[CW-1:0];
  assign shl_val = {lo[DW-2:0], 1'b0};
  assign shr_val = {lo[DW-1], lo[DW-1:1]};

  // Product magnitude must fit: up to 2^(DW-1) when negative, one less otherwise
  assign big = (hi != '0) || (neg ? (lo[DW-1] && (lo[DW-2:0] != '0)) : lo[DW-1]);

  // Select adder operands for the current step
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (state)
      S_IDLE: begin
        case (req.mode)
          MODE_NEG: begin
            add_y   = req.a;
            add_sub = 1'b1;
          end
          MODE_INC: begin
            add_x = req.a;
            add_y = {{(DW-1){1'b0}}, 1'b1};
          end
          MODE_DEC: begin
            add_x   = req.a;
            add_y   = {{(DW-1){1'b0}}, 1'b1};
            add_sub = 1'b1;
          end
          MODE_ADD: begin
            add_x = req.a;
            add_y = req.b;
          end
          MODE_SUB: begin
            add_x   = req.a;
            add_y   = req.b;
            add_sub = 1'b1;
          end
          default: begin
            add_x = '0;
          end
        endcase
      end
      S_MAGA: begin
        add_y   = mcand;
        add_sub = 1'b1;
      end
      S_MAGB: begin
        add_y   = lo;
        add_sub = 1'b1;
      end
      S_MUL: begin
        add_x = hi;
        add_y = mcand;
      end
      S_FIN: begin
        add_y   = lo;
        add_sub = 1'b1;
      end
      default: begin
        add_x = '0;
      end
    endcase
  end

  // Sequencer and datapath next values
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    hi_next        = hi;
    lo_next        = lo;
    mcand_next     = mcand;
    neg_next       = neg;
    lost_next      = lost;
    res_value_next = res_value;
    res_ref_next   = res_ref;
    case (state)
      S_IDLE: begin
        if (start) begin
          res_ref_next = 1'b0;
          state_next   = S_DONE;
          case (req.mode)
            MODE_LOAD: begin
              res_value_next = req.b;
            end
            MODE_NEG: begin
              res_value_next = add_r;
            end
            MODE_INC, MODE_DEC, MODE_ADD, MODE_SUB: begin
              res_value_next = add_r;
              res_ref_next   = add_ovf;
            end
            MODE_MUL: begin
              mcand_next = req.a;
              lo_next    = req.b;
              neg_next   = req.a[DW-1] ^ req.b[DW-1];
              state_next = S_MAGA;
            end
            MODE_SHL, MODE_SHR: begin
              lo_next        = req.a;
              lost_next      = 1'b0;
              cnt_next       = amt - CW'(1);
              res_value_next = req.a;
              if (amt_bad) begin
                res_ref_next = 1'b1;
              end else if (amt != '0) begin
                state_next = (req.mode == MODE_SHL) ? S_SHL : S_SHR;
              end
            end
            default: begin
              res_value_next = req.a;
            end
          endcase
        end
      end
      S_MAGA: begin
        if (mcand[DW-1]) begin
          mcand_next = add_r;
        end
        state_next = S_MAGB;
      end
      S_MAGB: begin
        if (lo[DW-1]) begin
          lo_next = add_r;
        end
        hi_next    = '0;
        cnt_next   = CW'(DW - 1);
        state_next = S_MUL;
      end
      S_MUL: begin
        if (lo[0]) begin
          hi_next = add_sum[DW:1];
          lo_next = {add_sum[0], lo[DW-1:1]};
        end else begin
          hi_next = {1'b0, hi[DW-1:1]};
          lo_next = {hi[0], lo[DW-1:1]};
        end
        cnt_next = cnt - CW'(1);
        if (cnt == '0) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        res_ref_next   = big;
        res_value_next = neg ? add_r : lo;
        state_next     = S_DONE;
      end
      S_SHL: begin
        lost_next = lost | (lo[DW-1] ^ lo[DW-2]);
        lo_next   = shl_val;
        cnt_next  = cnt - CW'(1);
        if (cnt == '0) begin
          res_ref_next   = lost | (lo[DW-1] ^ lo[DW-2]);
          res_value_next = shl_val;
          state_next     = S_DONE;
        end
      end
      S_SHR: begin
        lo_next  = shr_val;
        cnt_next = cnt - CW'(1);
        if (cnt == '0) begin
          res_ref_next   = 1'b0;
          res_value_next = shr_val;
          state_next     = S_DONE;
        end
      end
      S_DONE: begin
        if (ack) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cnt       <= cnt_next;
    hi        <= hi_next;
    lo        <= lo_next;
    mcand     <= mcand_next;
    neg       <= neg_next;
    lost      <= lost_next;
    res_value <= res_value_next;
    res_ref   <= res_ref_next;
  end

  assign rsp.done    = (state == S_DONE);
  assign rsp.refused = res_ref;
  assign rsp.value   = res_value;

endmodule

[sv/checked_accumulator_alu.sv]
// Top level: input handshake, accumulator, result register and the iterative ALU unit.
//
//   channel | direction | handshake            | payload
//   input   | in        | in_valid / in_ready   | mode, operand
//   output  | out       | out_valid / out_ready | acc_value, overflow_flag, upper_half, lower_half
//
// Load, negate, increment, decrement, add, subtract and unused modes go from the idle state
// straight to done. Multiply runs the shift-add loop, one adder pass per operand bit.
// Shifts move one bit per cycle; refused amounts go straight to done.
// One item is in the unit at a time; a new item is taken while a result waits in the
// output register. Reset clears the accumulator to zero and drops any pending result.
module checked_accumulator_alu import cal_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [3:0]           mode,
  input  logic signed [DW-1:0] operand,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [DW-1:0] acc_value,
  output logic                 overflow_flag,
  output logic signed [HW-1:0] upper_half,
  output logic [HW-1:0]        lower_half
);

  logic [DW-1:0] acc, acc_next;
  logic          busy;
  logic          start;
  logic          ack;
  cal_req_t      req;
  cal_rsp_t      rsp;

  assign in_ready = !busy;
  assign start    = in_valid && in_ready;
  assign ack      = rsp.done && (!out_valid || out_ready);

  assign req.mode = mode;
  assign req.a    = acc;
  assign req.b    = operand;

  // Keep the accumulator on a refused operation
  assign acc_next = rsp.refused ? acc : rsp.value;

  cal_unit u_unit (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .req   (req),
    .ack   (ack),
    .rsp   (rsp)
  );

  // Track the item in flight and the pending output transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      out_valid <= 1'b0;
      acc       <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
      end else if (ack) begin
        busy <= 1'b0;
      end
      if (ack) begin
        out_valid <= 1'b1;
        acc       <= acc_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (ack) begin
      acc_value     <= acc_next;
      overflow_flag <= rsp.refused;
      upper_half    <= acc_next[DW-1:HW];
      lower_half    <= acc_next[HW-1:0];
    end
  end

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    start |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_ack_busy: assert property (@(posedge clk) disable iff (rst)
    ack |-> busy)
    else $error("unit result handed over with no item in flight");

  a_refused_hold: assert property (@(posedge clk) disable iff (rst)
    (ack && rsp.refused) |=> (acc == $past(acc)))
    else $error("refused operation changed the accumulator");

  a_out_matches_acc: assert property (@(posedge clk) disable iff (rst)
    ack |=> (out_valid && (acc_value == acc)))
    else $error("result register disagrees with accumulator");

endmodule

[sim/checked_accumulator_alu_tb.sv]
// Self-checking testbench for the checked accumulator ALU: directed corners, random sequences.
module checked_accumulator_alu_tb import cal_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Modes past shift right leave the accumulator alone but still report it
  localparam logic [3:0] MODE_UNUSED_LO = 4'd9;
  localparam logic [3:0] MODE_UNUSED_HI = 4'd15;

  localparam int LONG_HOLD    = 400;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 60;
  localparam int BLOCK_ITEMS  = 300;
  localparam int NUM_BLOCKS   = 6;

  // Accumulator predictor and queue of results still owed by the block
  class acc_scoreboard;
    typedef struct packed {
      logic [DW-1:0] acc;
      logic          flag;
    } acc_result_t;

    logic [DW-1:0] accumulator;
    acc_result_t   owed_results[$];
    int            error_count;

    function new();
      accumulator = '0;
      error_count = 0;
    endfunction

    function int pending_count();
      return owed_results.size();
    endfunction

    // Apply one operation to the accumulator; return 1 when it is refused
    function logic apply_op(logic [3:0] op, logic [DW-1:0] opnd);
      logic [DW-1:0]        a;
      logic [DW-1:0]        b;
      logic [DW-1:0]        r;
      logic signed [DW:0]   wide;
      logic signed [2*DW-1:0] prod;
      logic signed [DW-1:0] sa;
      logic signed [DW-1:0] sr;
      logic                 refused;
      int unsigned          s;
      a = accumulator;
      r = a;
      refused = 1'b0;
      case (op)
        MODE_LOAD: r = opnd;
        MODE_NEG:  r = '0 - a;
        MODE_INC, MODE_DEC, MODE_ADD, MODE_SUB: begin
          b = (op == MODE_INC || op == MODE_DEC) ? 1 : opnd;
          if (op == MODE_INC || op == MODE_ADD)
            wide = $signed({a[DW-1], a}) + $signed({b[DW-1], b});
          else
            wide = $signed({a[DW-1], a}) - $signed({b[DW-1], b});
          refused = wide[DW] != wide[DW-1];
          r = wide[DW-1:0];
        end
        MODE_MUL: begin
          // product of two 32-bit values always fits in 64 bits
          prod = $signed({{DW{a[DW-1]}}, a}) * $signed({{DW{opnd[DW-1]}}, opnd});
          refused = (prod > 64'sh7FFFFFFF) || (prod < -64'sh80000000);
          r = prod[DW-1:0];
        end
        MODE_SHL, MODE_SHR: begin
          if (opnd[DW-1] || opnd >= DW) begin
            refused = 1'b1;
          end else begin
            s = 32'(opnd[CW-1:0]);
            sa = a;
            if (op == MODE_SHL) begin
              r = a << s;
              sr = r;
              // lost significant bits show up as a mismatch after shifting back
              if ((sr >>> s) != sa) refused = 1'b1;
            end else begin
              sr = sa >>> s;
              r = sr;
            end
          end
        end
        default: ;
      endcase
      if (refused) r = a;
      accumulator = r;
      return refused;
    endfunction

    function void note_transfer(logic [3:0] op, logic [DW-1:0] opnd);
      acc_result_t res;
      res.flag = apply_op(op, opnd);
      res.acc  = accumulator;
      owed_results.push_back(res);
    endfunction

    function void check_result(logic [DW-1:0] acc, logic flag, logic [HW-1:0] upper,
                               logic [HW-1:0] lower);
      acc_result_t res;
      if (owed_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: result with none outstanding: acc=%h flag=%b upper=%h lower=%h",
                   $realtime, acc, flag, upper, lower);
        return;
      end
      res = owed_results.pop_front();
      if (acc !== res.acc || flag !== res.flag || upper !== res.acc[DW-1:HW] ||
          lower !== res.acc[HW-1:0]) begin
        error_count++;
        if (error_count <= 10)
          $display("%0t: result error: expected acc=%h flag=%b upper=%h lower=%h, got %s",
                   $realtime, res.acc, res.flag, res.acc[DW-1:HW], res.acc[HW-1:0],
                   $sformatf("acc=%h flag=%b upper=%h lower=%h", acc, flag, upper, lower));
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [3:0]           mode = MODE_LOAD;
  logic signed [DW-1:0] operand = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] acc_value;
  logic                 overflow_flag;
  logic signed [HW-1:0] upper_half;
  logic [HW-1:0]        lower_half;

  acc_scoreboard acc_sb = new();
  int idle_cycles = 0;
  bit no_idle = 1'b0;
  bit rx_hold_req = 1'b0;

  checked_accumulator_alu DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .mode(mode),
    .operand(operand),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .acc_value(acc_value),
    .overflow_flag(overflow_flag),
    .upper_half(upper_half),
    .lower_half(lower_half)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Operand mix: full range, small values, shift amounts, extremes, powers of two
  function automatic logic [DW-1:0] rand_operand();
    logic [DW-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom;
      1: begin
        v = $urandom_range(0, 80);
        v = v - 40;
      end
      2: v = $urandom_range(0, 40);
      3: begin
        v = 1;
        v = v << $urandom_range(0, DW - 1);
        if ($urandom_range(0, 1)) v = '0 - v;
      end
      4: begin
        v = $urandom_range(0, 131071);
        v = v - 65536;
      end
      default: begin
        case ($urandom_range(0, 4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = '0;
          3: v = 32'hFFFF_FFFF;
          default: v = 32'h0000_FFFF;
        endcase
      end
    endcase
    return v;
  endfunction

  // Offer one item after a random gap and hold it until the transfer
  task automatic send_item(input logic [3:0] op, input logic [DW-1:0] opnd);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= op;
    operand  <= opnd;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (acc_sb.pending_count() != 0) @(posedge clk);
  endtask

  task automatic send_directed();
    send_item(MODE_LOAD, 32'h7FFF_FFFF);
    send_item(MODE_INC, 32'h0);           // increment at maximum
    send_item(MODE_ADD, 32'h1);
    send_item(MODE_SUB, 32'hFFFF_FFFF);
    send_item(MODE_MUL, 32'h2);
    send_item(MODE_MUL, 32'hFFFF_FFFF);
    send_item(MODE_DEC, 32'h0);
    send_item(MODE_DEC, 32'h0);           // decrement at minimum
    send_item(MODE_NEG, 32'h0);           // negate most negative wraps
    send_item(MODE_MUL, 32'h0);           // multiply by zero
    send_item(MODE_LOAD, 32'h8000_0000);
    send_item(MODE_MUL, 32'hFFFF_FFFF);
    send_item(MODE_SHR, 32'd31);
    send_item(MODE_SHR, 32'd32);          // amount too large
    send_item(MODE_SHL, 32'hFFFF_FFFF);   // negative amount
    send_item(MODE_SHL, 32'd0);           // shift by zero
    send_item(MODE_LOAD, 32'h1);
    send_item(MODE_SHL, 32'd30);
    send_item(MODE_SHL, 32'd1);           // would reach the sign bit
    send_item(MODE_SHR, 32'd0);
    send_item(MODE_UNUSED_LO, 32'h1234_5678);
    send_item(MODE_UNUSED_HI, 32'hFFFF_FFFF);
    send_item(MODE_LOAD, 32'hFFFF_8000);
    send_item(MODE_MUL, 32'hFFFF_0000);   // product of two negatives just past maximum
    send_item(MODE_SUB, 32'h8000_0000);
  endtask

  // Well-formed runs: a load followed by a handful of operations
  task automatic send_random_block(input int target);
    int sent;
    int n;
    logic [3:0] op;
    sent = 0;
    while (sent < target) begin
      send_item(MODE_LOAD, rand_operand());
      sent++;
      n = $urandom_range(3, 8);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) begin
          op = 4'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
          send_item(op, $urandom);
        end else begin
          op = 4'($urandom_range(MODE_NEG, MODE_SHR));
          send_item(op, rand_operand());
        end
        sent++;
      end
    end
  endtask

  // Sample transfers on both channels and track cycles without progress
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && out_ready)
        acc_sb.check_result(acc_value, overflow_flag, upper_half, lower_half);
      if (in_valid && in_ready)
        acc_sb.note_transfer(mode, operand);
      if ((out_valid && out_ready) || (in_valid && in_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random back-pressure, one long hold on request
  initial begin
    int gap;
    forever begin
      if (rx_hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        rx_hold_req = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap == 0) begin
          out_ready <= 1'b1;
          @(posedge clk);
        end else begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int blk;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_directed();
    for (blk = 0; blk < NUM_BLOCKS; blk++) begin
      no_idle = (blk == 1);
      if (blk == 2) rx_hold_req = 1'b1;
      if (blk == 4) wait_drained();
      send_random_block(BLOCK_ITEMS);
    end
    no_idle = 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (acc_sb.error_count == 0 && acc_sb.pending_count() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
